/* sv/tim_pkg.sv */
// ----------------------------------------------------------------------------
// tim_pkg
// Shared widths, defaults and the pipeline item type of the index mapper.
// ----------------------------------------------------------------------------
package tim_pkg;

    localparam int MAX_RANK_DEF = 8;
    localparam int IDX_W        = 31;
    localparam int SRC_W        = 32;
    localparam int SHIFT_W      = 5;
    localparam int RANK_W       = 4;
    localparam int DIM_W        = 3;

    localparam logic REG_RANK  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // One map item travelling down the row pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] rem;
        logic [SRC_W-1:0] src;
        logic [IDX_W-1:0] idx;
    } tim_item_t;

    // Loader status toward the top level
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SRC_W-1:0]   magic;
        logic [SHIFT_W-1:0] shift;
        logic [IDX_W-1:0]   divisor;
    } tim_load_res_t;

endpackage

/* sv/tim_if.sv */
// ----------------------------------------------------------------------------
// tim_in_if / tim_out_if
// Valid/ready channels of the index mapper.
// ----------------------------------------------------------------------------
interface tim_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  dim;
    logic [30:0] src_stride;
    logic [30:0] divisor;
    logic [30:0] linear_index;

    modport source (output valid, op, dim, src_stride, divisor, linear_index, input ready);
    modport sink   (input valid, op, dim, src_stride, divisor, linear_index, output ready);
endinterface

interface tim_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_index;
    logic [30:0] dest_index;

    modport source (output valid, source_index, dest_index, input ready);
    modport sink   (input valid, source_index, dest_index, output ready);
endinterface

/* sv/transpose_index_mapper.sv */
// ----------------------------------------------------------------------------
// transpose_index_mapper
// Maps a linear output index of a tensor transpose to its source index.
// ----------------------------------------------------------------------------
// A map item passes the entry register and then the register stages of every
// row before its result shows; one map item per cycle when not stalled.
// A load item runs in the loader (shift search plus a 32-step restoring
// division) and waits for the map pipeline to drain.
// Reset: asynchronous, active low; rank 1, count 0, rows reset to stride 0,
// divisor 1, magic 1, shift 0.
module transpose_index_mapper
    import tim_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    tim_in_if.sink      item,
    tim_out_if.source   result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [30:0] wr_data
);

    // configuration
    logic [RANK_W-1:0] rank_reg;
    logic [IDX_W-1:0]  count_reg;

    // dimension rows, each read at its own pipeline row
    logic [SRC_W-1:0]   stride_tab_reg  [MAX_RANK];
    logic [IDX_W-1:0]   divisor_tab_reg [MAX_RANK];
    logic [SRC_W-1:0]   magic_tab_reg   [MAX_RANK];
    logic [SHIFT_W-1:0] shift_tab_reg   [MAX_RANK];

    // pending load
    logic [DIM_W-1:0] ld_dim_reg;
    logic [IDX_W-1:0] ld_stride_reg;

    tim_load_res_t ldr;
    tim_item_t     entry_reg;
    tim_item_t     chain [MAX_RANK+1];
    logic [MAX_RANK-1:0] row_busy;

    logic adv, acc, empty, tab_wr;

    // the whole pipeline moves as one; output holds while stalled
    assign adv   = !chain[MAX_RANK].valid || result.ready;
    assign item.ready = !ldr.busy && adv;
    assign acc   = item.valid && item.ready;
    assign empty = !entry_reg.valid && (row_busy == '0);
    // rows are rewritten only when no map item can still read them
    assign tab_wr = ldr.done && empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= RANK_W'(1);
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RANK:  rank_reg  <= wr_data[RANK_W-1:0];
                REG_COUNT: count_reg <= wr_data;
                default:   rank_reg  <= rank_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && item.op == OP_LOAD)
        begin
            ld_dim_reg    <= item.dim;
            ld_stride_reg <= item.src_stride;
        end
    end

    tim_loader u_loader (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (acc && item.op == OP_LOAD),
        .divisor (item.divisor),
        .ack     (tab_wr),
        .res     (ldr)
    );

    generate
        for (genvar r = 0; r < MAX_RANK; r++)
        begin : g_tab
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stride_tab_reg[r]  <= '0;
                    divisor_tab_reg[r] <= IDX_W'(1);
                    magic_tab_reg[r]   <= SRC_W'(1);
                    shift_tab_reg[r]   <= '0;
                end
                else if (tab_wr && int'(ld_dim_reg) == r)
                begin
                    stride_tab_reg[r]  <= {1'b0, ld_stride_reg};
                    divisor_tab_reg[r] <= ldr.divisor;
                    magic_tab_reg[r]   <= ldr.magic;
                    shift_tab_reg[r]   <= ldr.shift;
                end
            end
        end
    endgenerate

    // entry stage drops indices at or above the element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (adv)
        begin
            entry_reg.valid <= acc && item.op == OP_MAP && item.linear_index < count_reg;
            entry_reg.rem   <= item.linear_index;
            entry_reg.src   <= '0;
            entry_reg.idx   <= item.linear_index;
        end
    end

    assign chain[0] = entry_reg;

    generate
        for (genvar r = 0; r < MAX_RANK; r++)
        begin : g_row
            tim_row #(
                .ROW (r)
            ) u_row (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .rank     (rank_reg),
                .magic    (magic_tab_reg[r]),
                .shift    (shift_tab_reg[r]),
                .divisor  (divisor_tab_reg[r]),
                .stride   (stride_tab_reg[r]),
                .in_item  (chain[r]),
                .out_item (chain[r+1]),
                .busy     (row_busy[r])
            );
        end
    endgenerate

    assign result.valid        = chain[MAX_RANK].valid;
    assign result.source_index = chain[MAX_RANK].src;
    assign result.dest_index   = chain[MAX_RANK].idx;

endmodule

/* sv/tim_loader.sv */
// ----------------------------------------------------------------------------
// tim_loader
// Derives shift = ceil(log2 d) and the 32-bit magic multiplier of a divisor.
// ----------------------------------------------------------------------------
module tim_loader
    import tim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IDX_W-1:0]    divisor,
    input  logic                ack,
    output tim_load_res_t       res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [SHIFT_W-1:0] sh_reg, sh_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]   d_reg, d_next;
    logic [SRC_W-1:0]   r_reg, r_next;
    logic [SRC_W-1:0]   q_reg, q_next;
    logic [SRC_W-1:0]   magic_reg, magic_next;
    logic [SRC_W:0]     r2;
    logic [SRC_W-1:0]   pow;
    logic               qbit;

    assign pow  = 32'd1 << sh_reg;
    assign r2   = {r_reg, 1'b0};
    assign qbit = (r2 >= {2'b0, d_reg});

    always_comb
    begin
        state_next = state_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        magic_next = magic_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    d_next     = (divisor == '0) ? 31'd1 : divisor;
                    sh_next    = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (sh_reg < 5'd31 && pow < {1'b0, d_reg})
                begin
                    sh_next = sh_reg + 5'd1;
                end
                else
                begin
                    r_next     = pow - {1'b0, d_reg};
                    q_next     = '0;
                    cnt_next   = 5'd31;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                r_next = qbit ? 32'(r2 - {2'b0, d_reg}) : r2[SRC_W-1:0];
                q_next = {q_reg[SRC_W-2:0], qbit};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    magic_next = {q_reg[SRC_W-2:0], qbit} + 32'd1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        cnt_reg   <= cnt_next;
        d_reg     <= d_next;
        r_reg     <= r_next;
        q_reg     <= q_next;
        magic_reg <= magic_next;
    end

    assign res.busy    = (state_reg != ST_IDLE);
    assign res.done    = (state_reg == ST_HOLD);
    assign res.magic   = magic_reg;
    assign res.shift   = sh_reg;
    assign res.divisor = d_reg;

endmodule

/* sv/tim_row.sv */
// ----------------------------------------------------------------------------
// tim_row
// One dimension row of the map pipeline: four register stages.
// ----------------------------------------------------------------------------
module tim_row
    import tim_pkg::*;
#(
    parameter int ROW = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [RANK_W-1:0]  rank,
    input  logic [SRC_W-1:0]   magic,
    input  logic [SHIFT_W-1:0] shift,
    input  logic [IDX_W-1:0]   divisor,
    input  logic [SRC_W-1:0]   stride,
    input  tim_item_t          in_item,
    output tim_item_t          out_item,
    output logic               busy
);

    tim_item_t        a_reg, b_reg, c_reg, d_reg;
    logic [SRC_W-1:0] a_t_reg;
    logic [IDX_W-1:0] b_q_reg;
    logic [SRC_W-1:0] c_pd_reg, c_ps_reg;

    logic [63:0]      mul_hi;
    logic [SRC_W:0]   sum;
    logic [SRC_W:0]   qw;
    logic [SRC_W-1:0] pd, ps;
    logic             active;
    tim_item_t        d_next;

    assign active = (ROW < int'(rank));
    assign mul_hi = {32'd0, magic} * {33'd0, in_item.rem};
    assign sum    = {1'b0, a_t_reg} + {2'b0, a_reg.rem};
    assign qw     = sum >> shift;
    assign pd     = {1'b0, b_q_reg} * {1'b0, divisor};
    assign ps     = {1'b0, b_q_reg} * stride;

    always_comb
    begin
        d_next = c_reg;
        if (active)
        begin
            d_next.rem = c_reg.rem - c_pd_reg[IDX_W-1:0];
            d_next.src = c_reg.src + c_ps_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else if (adv)
        begin
            a_reg <= in_item;
            b_reg <= a_reg;
            c_reg <= b_reg;
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_t_reg  <= mul_hi[63:32];
            b_q_reg  <= qw[IDX_W-1:0];
            c_pd_reg <= pd;
            c_ps_reg <= ps;
        end
    end

    assign out_item = d_reg;
    assign busy     = a_reg.valid | b_reg.valid | c_reg.valid | d_reg.valid;

endmodule

/* sv/tim_checker.sv */
// ----------------------------------------------------------------------------
// tim_checker
// Port-level checks of the index mapper, bound to the top level.
// ----------------------------------------------------------------------------
module tim_checker
    import tim_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_source_index,
    input logic [30:0] out_dest_index,
    input logic        wr_en,
    input logic        wr_index,
    input logic [30:0] wr_data
);

    logic [30:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en && wr_index == REG_COUNT)
        begin
            count_reg <= wr_data;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_source_index)
            && $stable(out_dest_index))
        else $error("stalled result changed");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op == OP_LOAD |=> !in_ready)
        else $error("input taken while a load is in progress");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_dest_index < count_reg)
        else $error("result for an index beyond the element count");

endmodule

bind transpose_index_mapper tim_checker u_tim_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item.valid),
    .in_ready         (item.ready),
    .in_op            (item.op),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_source_index (result.source_index),
    .out_dest_index   (result.dest_index),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data)
);

/* verif/tb_transpose_index_mapper.sv */
// ----------------------------------------------------------------------------
// tb_transpose_index_mapper
// Self-checking bench for the transpose index mapper: directed table of
// loads and maps, then random row tables and indices, all results scored
// against an in-bench divide-and-accumulate predictor.
// ----------------------------------------------------------------------------
module tb_transpose_index_mapper;
    import tim_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int N_RANDOM      = 1200;

    typedef struct {
        logic        op;
        logic [2:0]  dim;
        logic [30:0] stride;
        logic [30:0] divisor;
        logic [30:0] idx;
        bit          has_exp;   // typed-in expectation present
        logic [31:0] exp_src;
    } stim_row_t;

    typedef struct {
        logic [31:0] src;
        logic [30:0] dst;
    } mapped_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic [30:0] wr_data;

    tim_in_if  item_if ();
    tim_out_if result_if ();

    transpose_index_mapper i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_if.sink),
        .result   (result_if.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predictor state: shadow of the row tables and the two registers
    logic [31:0] row_stride  [8];
    logic [30:0] row_divisor [8];
    logic [31:0] row_magic   [8];
    logic [4:0]  row_shift   [8];
    logic [3:0]  cur_rank;
    logic [30:0] cur_count;

    mapped_t pending_maps[$];
    int      n_errors;
    int      n_loads;
    int      n_maps_checked;
    int      idle_cycles;
    bit      rx_hold_long;   // set by stimulus to request a long receiver stall
    bit      rx_no_idle;     // last part of the run: no receiver stalls

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%08h expected 0x%08h", what, got, want);
        n_errors++;
    endtask

    // Shift is ceil(log2 d) capped at 31; magic = ((2^sh - d) << 32) / d + 1
    function automatic void predict_load(input logic [2:0] dim, input logic [30:0] stride,
                                         input logic [30:0] dv);
        logic [63:0] d;
        logic [63:0] m;
        int sh;
        d  = (dv == 0) ? 64'd1 : {33'd0, dv};
        sh = 0;
        while (sh < 31 && (64'd1 << sh) < d)
            sh++;
        m = ((((64'd1 << sh) - d)) << 32) / d + 64'd1;
        row_stride[dim]  = {1'b0, stride};
        row_divisor[dim] = d[30:0];
        row_magic[dim]   = m[31:0];
        row_shift[dim]   = sh[4:0];
    endfunction

    function automatic logic [31:0] predict_source(input logic [30:0] idx);
        logic [63:0] rem;
        logic [63:0] t;
        logic [63:0] q;
        logic [31:0] src;
        int n;
        rem = {33'd0, idx};
        src = '0;
        n   = (cur_rank > 8) ? 8 : cur_rank;
        for (int i = 0; i < n; i++)
        begin
            t   = ({32'd0, row_magic[i]} * rem) >> 32;
            q   = (t + rem) >> row_shift[i];
            rem = (rem - ((q * {33'd0, row_divisor[i]}) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF;
            src = src + 32'(q * {32'd0, row_stride[i]});
        end
        return src;
    endfunction

    // Configuration writes; only called with the block idle
    task automatic write_reg(input logic idx, input logic [30:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_RANK)
            cur_rank = val[3:0];
        else
            cur_count = val;
    endtask

    // Drive one item and wait for its transfer; the predictor runs on accept
    task automatic send_item(input logic op, input logic [2:0] dim,
                             input logic [30:0] stride, input logic [30:0] dv,
                             input logic [30:0] idx, input bit has_exp,
                             input logic [31:0] exp_src, input bit allow_gap);
        mapped_t m;
        if (allow_gap && ($urandom_range(0, 5) == 0))
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.op           <= op;
        item_if.dim          <= dim;
        item_if.src_stride   <= stride;
        item_if.divisor      <= dv;
        item_if.linear_index <= idx;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        // transfer happened at this edge
        if (op == OP_LOAD)
        begin
            predict_load(dim, stride, dv);
            n_loads++;
        end
        else if (idx < cur_count)
        begin
            m.src = predict_source(idx);
            m.dst = idx;
            if (has_exp && m.src !== exp_src)
                report_mismatch("predictor vs table", m.src, exp_src);
            pending_maps.push_back(m);
        end
    endtask

    task automatic drain_and_settle();
        item_if.valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stall bursts, a long stall on request
    initial
    begin
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_long)
            begin
                result_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
                rx_hold_long = 1'b0;
            end
            else if (!rx_no_idle && $urandom_range(0, 7) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Scoreboard: compare each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        mapped_t e;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_maps.size() == 0)
            begin
                report_mismatch("unexpected result", result_if.source_index, 32'd0);
            end
            else
            begin
                e = pending_maps.pop_front();
                if (result_if.source_index !== e.src)
                    report_mismatch("source_index", result_if.source_index, e.src);
                if (result_if.dest_index !== e.dst)
                    report_mismatch("dest_index", {1'b0, result_if.dest_index},
                                    {1'b0, e.dst});
                n_maps_checked++;
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    stim_row_t directed[$];

    function automatic stim_row_t mk(input logic op, input logic [2:0] dim,
                                     input logic [30:0] s, input logic [30:0] d,
                                     input logic [30:0] idx, input bit he,
                                     input logic [31:0] es);
        stim_row_t r;
        r.op = op; r.dim = dim; r.stride = s; r.divisor = d; r.idx = idx;
        r.has_exp = he; r.exp_src = es;
        return r;
    endfunction

    // Random row with mostly small divisors, occasionally extreme ones
    task automatic send_random_load(input bit gap);
        logic [30:0] dv;
        logic [30:0] s;
        case ($urandom_range(0, 5))
            0: dv = 31'($urandom);
            1: dv = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            2: dv = 31'($urandom_range(0, 2));
            default: dv = 31'($urandom_range(1, 64));
        endcase
        s = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4096));
        send_item(OP_LOAD, 3'($urandom), s, dv, '0, 1'b0, '0, gap);
    endtask

    task automatic send_random_map(input bit gap);
        logic [30:0] idx;
        case ($urandom_range(0, 7))
            0: idx = 31'($urandom);
            1: idx = cur_count;                 // exactly at the bound: no result
            2: idx = (cur_count == 0) ? 31'd0 : cur_count - 1;
            default: idx = (cur_count == 0) ? 31'd0
                           : 31'($urandom_range(0, cur_count - 1));
        endcase
        send_item(OP_MAP, 3'($urandom), 31'($urandom), 31'($urandom), idx, 1'b0, '0, gap);
    endtask

    initial
    begin
        logic [30:0] count_set [4];
        n_errors = 0; n_loads = 0; n_maps_checked = 0; idle_cycles = 0;
        rx_hold_long = 1'b0; rx_no_idle = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0; wr_index = REG_RANK; wr_data = '0;
        item_if.valid = 1'b0; item_if.op = OP_LOAD; item_if.dim = '0;
        item_if.src_stride = '0; item_if.divisor = '0; item_if.linear_index = '0;
        cur_rank = 4'd1; cur_count = '0;
        for (int i = 0; i < 8; i++)
        begin
            row_stride[i] = '0; row_divisor[i] = 31'd1; row_magic[i] = 32'd1;
            row_shift[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Count 0 after reset: maps give no result
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'd0, 1'b0, '0));
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'h7FFF_FFFF, 1'b0, '0));
        foreach (directed[i])
            send_item(directed[i].op, directed[i].dim, directed[i].stride,
                      directed[i].divisor, directed[i].idx, 1'b0, '0, 1'b0);
        directed.delete();
        drain_and_settle();

        write_reg(REG_COUNT, 31'h7FFF_FFFF);
        // Reset rows: rank 1, stride 0 -> source 0
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'd0, 1'b1, 32'd0));
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'h7FFF_FFFE, 1'b1, 32'd0));
        // Zero divisor stored as one; max stride times max quotient wraps
        directed.push_back(mk(OP_LOAD, 0, 31'h7FFF_FFFF, 31'd0, 0, 1'b0, '0));
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'h7FFF_FFFE, 1'b1, 32'h8000_0002));
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'd1, 1'b1, 32'h7FFF_FFFF));
        // Max divisor: quotient 0 below it
        directed.push_back(mk(OP_LOAD, 0, 31'd5, 31'h7FFF_FFFF, 0, 1'b0, '0));
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'h7FFF_FFFE, 1'b1, 32'd0));
        directed.push_back(mk(OP_LOAD, 0, 31'd1, 31'd1, 0, 1'b0, '0));
        directed.push_back(mk(OP_MAP, 0, 0, 0, 31'd12345, 1'b1, 32'd12345));
        // Power-of-two and odd divisors on the other rows
        directed.push_back(mk(OP_LOAD, 7, 31'd3, 31'd1024, 0, 1'b0, '0));
        directed.push_back(mk(OP_LOAD, 1, 31'd7, 31'd3, 0, 1'b0, '0));
        directed.push_back(mk(OP_LOAD, 2, 31'd11, 31'd1_000_003, 0, 1'b0, '0));
        foreach (directed[i])
            send_item(directed[i].op, directed[i].dim, directed[i].stride,
                      directed[i].divisor, directed[i].idx, directed[i].has_exp,
                      directed[i].exp_src, 1'b0);
        directed.delete();
        drain_and_settle();

        // Rank extremes: 0 gives source 0, 15 walks only eight rows
        write_reg(REG_RANK, 31'd0);
        send_item(OP_MAP, 0, 0, 0, 31'd999, 1'b1, 32'd0, 1'b0);
        drain_and_settle();
        write_reg(REG_RANK, 31'd15);
        for (int i = 0; i < 6; i++)
            send_item(OP_MAP, 0, 0, 0, 31'($urandom), 1'b0, '0, 1'b0);
        drain_and_settle();
        write_reg(REG_RANK, 31'd8);
        write_reg(REG_COUNT, 31'd1);
        send_item(OP_MAP, 0, 0, 0, 31'd0, 1'b0, '0, 1'b0);
        send_item(OP_MAP, 0, 0, 0, 31'd1, 1'b0, '0, 1'b0);
        drain_and_settle();

        // Random phases: each reprograms rank/count, loads a table, then maps with occasional loads
        count_set[0] = 31'h7FFF_FFFF;
        count_set[1] = 31'd1000;
        count_set[2] = 31'd0;
        count_set[3] = 31'd64;
        for (int ph = 0; ph < 12; ph++)
        begin
            int n_items;
            write_reg(REG_RANK, 31'($urandom_range(0, 15)));
            write_reg(REG_COUNT, (ph % 4 == 0) ? 31'($urandom) : count_set[ph % 4]);
            for (int r = 0; r < 8; r++)
                send_random_load(1'b1);
            if (ph == 11)
                rx_no_idle = 1'b1;
            n_items = N_RANDOM / 12;
            for (int k = 0; k < n_items; k++)
            begin
                // Long receiver stall while the sender keeps going
                if (ph == 3 && k == 10)
                    rx_hold_long = 1'b1;
                if ($urandom_range(0, 15) == 0)
                    send_random_load(ph != 11);
                else
                    send_random_map(ph != 11);
            end
            // Sender pauses until every expected result has come
            drain_and_settle();
        end

        drain_and_settle();
        $display("covered %0d row loads and %0d checked mappings over rank 0..15",
                 n_loads, n_maps_checked);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
